// ----- hw/rtl/pgvd_pkg.sv -----
// Package for the pairwise gravity velocity-change core: widths, register
// indexes and the pipeline stage records. No dependencies.
`default_nettype none

package pgvd_pkg;

  localparam int CW     = 32;              // position / mass / register width
  localparam int MAG_W  = CW + 1;          // axis difference magnitude
  localparam int SQ_W   = 2 * MAG_W;       // one squared difference
  localparam int SUM_W  = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W = SUM_W / 2;       // floor(sqrt(sum))
  localparam int REM_W  = SUM_W + 2;       // root extraction remainder
  localparam int HALF_W = SUM_W / 2;       // split of the sum for S*r
  localparam int K_W    = 3 * CW;          // G*dt*m
  localparam int NUM_W  = K_W + MAG_W;     // K*|D|
  localparam int DEN_W  = SUM_W + ROOT_W;  // S*r
  localparam int OUT_W  = 48;
  localparam int QB     = OUT_W - 1;       // quotient bits before saturation
  localparam int LANES  = 6;

  localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {QB{1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {QB{1'b0}}};

  typedef enum logic [1:0] {
    REG_DIMS  = 2'd0,
    REG_TSTEP = 2'd1,
    REG_GRAV  = 2'd2
  } cfg_reg_e;

  // k[0]: G*dt*m_second (first body), k[1]: G*dt*m_first (second body)
  typedef struct packed {
    logic [1:0][K_W-1:0]   k;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [SUM_W-1:0]    s;
    logic [ROOT_W-1:0]   root;
    logic [REM_W-1:0]    rem;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0]            den;
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QB-1:0]    q;
    logic [LANES-1:0]            ovf;
    logic [LANES-1:0]            neg;
    logic                        coin;
  } div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pairwise_gravity_velocity_delta_core.sv -----
// Pairwise gravity velocity-change core, fully pipelined.
// Depends on pgvd_pkg.
`default_nettype none

// One body pair per cycle in and one result per cycle out, while the output
// register is not stalled. The depth is set by the one-bit-per-stage square
// root (34 stages over the 68-bit sum of squares) and the one-bit-per-stage
// divider (an overflow stage plus 47 quotient stages, six lanes side by side
// sharing the divisor S*r). The whole pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage in place;
// bubbles are carried, not squeezed.
// Results: trunc(G*m*dt*D / (S*floor(sqrt S))) per axis, saturated to 48 bits.
// tuser flags coincident bodies (all changes zero). Registers are to be written by
// the user only while the pipeline is empty (not enforced); the stages read them live.
module pairwise_gravity_velocity_delta_core
  import pgvd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CW-1:0]         cfg_wdata_i,
  // input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // first_mass, second_mass (32 bits each, lowest first)
  input  wire logic [8*CW-1:0]       s_axis_tdata_i,
  // output stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // first_dvx, first_dvy, first_dvz, second_dvx, second_dvy, second_dvz
  // (48 bits each, lowest first)
  output logic [LANES*OUT_W-1:0]     m_axis_tdata_o,
  // coincident
  output logic [0:0]                 m_axis_tuser_o
);

  // ---------------- configuration registers ----------------
  logic [1:0]    dims_q;
  logic [CW-1:0] tstep_q, grav_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= 2'd3;
      tstep_q <= CW'(65536);
      grav_q  <= CW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DIMS:  dims_q  <= cfg_wdata_i[1:0];
        REG_TSTEP: tstep_q <= cfg_wdata_i;
        REG_GRAV:  grav_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic out_v_q;
  logic adv;
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  wire logic in_fire     = s_axis_tvalid_i && adv;

  // ---------------- F1: differences, G*dt ----------------
  logic [2:0]            axis_use;
  logic [2:0][MAG_W-1:0] f1_diff;
  logic [2:0][MAG_W-1:0] f1_mag_d;
  logic [2:0]            f1_neg_d;

  // dimension count 0 acts as one axis
  assign axis_use = {dims_q == 2'd3, dims_q[1], 1'b1};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      f1_diff[j] = {s_axis_tdata_i[j*CW + CW-1], s_axis_tdata_i[j*CW +: CW]}
                 - {s_axis_tdata_i[(3+j)*CW + CW-1], s_axis_tdata_i[(3+j)*CW +: CW]};
      if (!axis_use[j]) f1_diff[j] = '0;
      f1_neg_d[j] = f1_diff[j][MAG_W-1];
      f1_mag_d[j] = f1_neg_d[j] ? MAG_W'(-f1_diff[j]) : f1_diff[j];
    end
  end

  logic                  f1_v_q;
  logic [2:0][MAG_W-1:0] f1_mag_q;
  logic [2:0]            f1_neg_q;
  logic [1:0][CW-1:0]    f1_mass_q;   // [0]: m_second, [1]: m_first
  logic [2*CW-1:0]       f1_gd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_mag_q     <= f1_mag_d;
      f1_neg_q     <= f1_neg_d;
      f1_mass_q[0] <= s_axis_tdata_i[7*CW +: CW];
      f1_mass_q[1] <= s_axis_tdata_i[6*CW +: CW];
      f1_gd_q      <= grav_q * tstep_q;
    end
  end

  // ---------------- F2: squares, G*dt*m partials ----------------
  logic                  f2_v_q;
  logic [2:0][SQ_W-1:0]  f2_sq_q;
  logic [1:0][2*CW-1:0]  f2_klo_q, f2_khi_q;
  logic [2:0][MAG_W-1:0] f2_mag_q;
  logic [2:0]            f2_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) f2_sq_q[j] <= f1_mag_q[j] * f1_mag_q[j];
      for (int b = 0; b < 2; b++) begin
        f2_klo_q[b] <= f1_gd_q[CW-1:0]  * f1_mass_q[b];
        f2_khi_q[b] <= f1_gd_q[2*CW-1:CW] * f1_mass_q[b];
      end
      f2_mag_q <= f1_mag_q;
      f2_neg_q <= f1_neg_q;
    end
  end

  // ---------------- F3 / square root pipeline ----------------
  sqrt_t sq_q  [ROOT_W+1];
  logic  sqv_q [ROOT_W+1];
  sqrt_t sq0_d;

  always_comb begin
    sq0_d.s = SUM_W'(f2_sq_q[0]) + SUM_W'(f2_sq_q[1]) + SUM_W'(f2_sq_q[2]);
    for (int b = 0; b < 2; b++)
      sq0_d.side.k[b] = K_W'(f2_klo_q[b]) + (K_W'(f2_khi_q[b]) << CW);
    sq0_d.side.mag = f2_mag_q;
    sq0_d.side.neg = f2_neg_q;
    sq0_d.root     = '0;
    sq0_d.rem      = REM_W'(sq0_d.s);
  end

  always_ff @(posedge clk_i) begin
    if (adv) sq_q[0] <= sq0_d;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - i;
    logic [REM_W-1:0] trial;
    sqrt_t            nxt;
    // (r + 2^B)^2 - r^2
    assign trial = (REM_W'(sq_q[i].root) << (B + 1)) | (REM_W'(1) << (2 * B));
    always_comb begin
      nxt = sq_q[i];
      if (sq_q[i].rem >= trial) begin
        nxt.rem     = sq_q[i].rem - trial;
        nxt.root[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[i+1] <= nxt;
    end
  end

  // ---------------- N1: S*r and K*|D| partial products ----------------
  logic                             n1_v_q;
  logic [1:0][2*HALF_W-1:0]         n1_den_pp_q;
  logic [LANES-1:0][2:0][CW+MAG_W-1:0] n1_num_pp_q;
  logic [LANES-1:0]                 n1_neg_q;
  logic                             n1_coin_q;

  sqrt_t sq_end;
  assign sq_end = sq_q[ROOT_W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_den_pp_q[0] <= sq_end.s[HALF_W-1:0] * sq_end.root;
      n1_den_pp_q[1] <= sq_end.s[SUM_W-1:HALF_W] * sq_end.root;
      n1_coin_q      <= (sq_end.s == '0);
      // lane = body * 3 + axis
      for (int b = 0; b < 2; b++) begin
        for (int a = 0; a < 3; a++) begin
          for (int c = 0; c < 3; c++)
            n1_num_pp_q[b*3+a][c] <= sq_end.side.k[b][c*CW +: CW] * sq_end.side.mag[a];
          // first body moves toward the second: sign flips for body 0
          n1_neg_q[b*3+a] <= (b == 0) ? !sq_end.side.neg[a] : sq_end.side.neg[a];
        end
      end
    end
  end

  // ---------------- N2 / divider pipeline ----------------
  div_t dq_q  [QB+2];
  logic dqv_q [QB+2];
  div_t dq0_d;

  always_comb begin
    dq0_d.den = DEN_W'(n1_den_pp_q[0]) + (DEN_W'(n1_den_pp_q[1]) << HALF_W);
    for (int l = 0; l < LANES; l++) begin
      dq0_d.rem[l] = NUM_W'(n1_num_pp_q[l][0])
                   + (NUM_W'(n1_num_pp_q[l][1]) << CW)
                   + (NUM_W'(n1_num_pp_q[l][2]) << (2 * CW));
    end
    dq0_d.q    = '0;
    dq0_d.ovf  = '0;
    dq0_d.neg  = n1_neg_q;
    dq0_d.coin = n1_coin_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) dq_q[0] <= dq0_d;
  end

  // overflow: quotient of 2^47 or more saturates either sign
  div_t ovf_d;
  always_comb begin
    ovf_d = dq_q[0];
    for (int l = 0; l < LANES; l++)
      ovf_d.ovf[l] = (dq_q[0].rem[l] >> QB) >= NUM_W'(dq_q[0].den);
  end
  always_ff @(posedge clk_i) begin
    if (adv) dq_q[1] <= ovf_d;
  end

  for (genvar t = 1; t <= QB; t++) begin : g_div
    localparam int B = QB - t;
    div_t nxt;
    always_comb begin
      nxt = dq_q[t];
      for (int l = 0; l < LANES; l++) begin
        if ((dq_q[t].rem[l] >> B) >= NUM_W'(dq_q[t].den)) begin
          nxt.rem[l]  = dq_q[t].rem[l] - (NUM_W'(dq_q[t].den) << B);
          nxt.q[l][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) dq_q[t+1] <= nxt;
    end
  end

  // ---------------- output: sign, saturation, coincident ----------------
  div_t                        dq_end;
  logic [LANES-1:0][OUT_W-1:0] out_d;
  logic [LANES-1:0][OUT_W-1:0] out_q;
  logic                        out_coin_q;

  assign dq_end = dq_q[QB+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dq_end.coin)      out_d[l] = '0;
      else if (dq_end.neg[l])
        out_d[l] = dq_end.ovf[l] ? NEG_LIMIT : OUT_W'(-{1'b0, dq_end.q[l]});
      else
        out_d[l] = dq_end.ovf[l] ? POS_LIMIT : {1'b0, dq_end.q[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q      <= out_d;
      out_coin_q <= dq_end.coin;
    end
  end

  assign m_axis_tvalid_o   = out_v_q;
  assign m_axis_tdata_o    = out_q;
  assign m_axis_tuser_o[0] = out_coin_q;

  // ---------------- valid chain ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      n1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= ROOT_W; i++) sqv_q[i] <= 1'b0;
      for (int i = 0; i <= QB + 1; i++) dqv_q[i] <= 1'b0;
    end else if (adv) begin
      f1_v_q   <= in_fire;
      f2_v_q   <= f1_v_q;
      sqv_q[0] <= f2_v_q;
      for (int i = 0; i < ROOT_W; i++) sqv_q[i+1] <= sqv_q[i];
      n1_v_q   <= sqv_q[ROOT_W];
      dqv_q[0] <= n1_v_q;
      for (int i = 0; i <= QB; i++) dqv_q[i+1] <= dqv_q[i];
      out_v_q  <= dqv_q[QB+1];
    end
  end

  // ---------------- assertions ----------------
  logic [REM_W-1:0] root_sq, root_next_sq;
  assign root_sq      = REM_W'(sq_end.root) * REM_W'(sq_end.root);
  assign root_next_sq = (REM_W'(sq_end.root) + REM_W'(1)) * (REM_W'(sq_end.root) + REM_W'(1));

  // root pipeline delivers floor(sqrt(S))
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqv_q[ROOT_W] |-> (root_sq <= REM_W'(sq_end.s)) && (root_next_sq > REM_W'(sq_end.s)))
    else $error("square root stage result is not floor(sqrt(S))");

  // coincident results carry no velocity change
  a_coin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("coincident result with nonzero velocity change");

  // a held result does not change while the pipeline is frozen
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(out_q) && $stable(out_coin_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
